### sv/dsa_pkg.sv
// Package: payload types, register indexes and sequencer states for the DSA engine.
package dsa_pkg;

  localparam int unsigned W = 32;

  // configuration register indexes
  localparam logic [2:0] REG_P = 3'd0;
  localparam logic [2:0] REG_Q = 3'd1;
  localparam logic [2:0] REG_G = 3'd2;
  localparam logic [2:0] REG_X = 3'd3;
  localparam logic [2:0] REG_Y = 3'd4;

  localparam logic KIND_SIGN   = 1'b0;
  localparam logic KIND_VERIFY = 1'b1;

  typedef struct packed {
    logic          kind;
    logic [W-1:0]  hash_value;
    logic [W-1:0]  nonce;
    logic [W-1:0]  sig_r;
    logic [W-1:0]  sig_s;
  } in_item_t;

  typedef struct packed {
    logic [W-1:0]  out_r;
    logic [W-1:0]  out_s;
    logic          valid_res;
    logic          status;
  } out_item_t;

  // operations of the shared bit-serial unit
  typedef enum logic [1:0] {
    OP_MULMOD = 2'd0,  // (a*b) mod m, one multiplier bit a cycle
    OP_RED    = 2'd1,  // a mod m, one quotient bit a cycle
    OP_DIV    = 2'd2   // a / m and a mod m
  } op_t;

  typedef struct packed {
    logic          start;
    op_t           op;
  } unit_ctl_t;

  typedef struct packed {
    logic          busy;
    logic          done;
  } unit_sts_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_CHECK,
    S_INV_INIT, S_INV_RED, S_INV_RED_W, S_INV_TEST, S_INV_DIV, S_INV_DIV_W,
    S_INV_MUL, S_INV_MUL_W, S_INV_UPD, S_INV_END, S_INV_FIX, S_INV_FIX_W,
    S_PW_INIT, S_PW_BRED, S_PW_BRED_W, S_PW_BIT, S_PW_ACC, S_PW_ACC_W,
    S_PW_SQ, S_PW_SQ_W, S_PW_DONE,
    S_SG_R, S_SG_R_W, S_SG_INV,
    S_SG_H, S_SG_H_W, S_SG_X, S_SG_X_W, S_SG_XR, S_SG_XR_W,
    S_SG_ADD, S_SG_ADD_W, S_SG_S, S_SG_S_W,
    S_VF_U1, S_VF_U1_W, S_VF_U2, S_VF_U2_W, S_VF_T1, S_VF_T2,
    S_VF_M, S_VF_M_W, S_VF_V, S_VF_V_W,
    S_FAIL, S_DONE, S_OUT
  } state_t;

endpackage

### sv/dsa_serial_unit.sv
// Bit-serial modular multiply, reduce and divide unit.
module dsa_serial_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  dsa_pkg::unit_ctl_t        ctl,
  input  logic [2*dsa_pkg::W-1:0]   a,
  input  logic [dsa_pkg::W-1:0]     b,
  input  logic [dsa_pkg::W-1:0]     m,
  output dsa_pkg::unit_sts_t        sts,
  output logic [2*dsa_pkg::W-1:0]   quo,
  output logic [dsa_pkg::W-1:0]     rem
);
  localparam int unsigned W = dsa_pkg::W;

  logic [2*W-1:0] sh;
  logic [W:0]     acc;
  logic [W-1:0]   mm;
  logic [6:0]     cnt;
  dsa_pkg::op_t   op;
  logic           busy;
  logic           done;
  logic [W-1:0]   bb;

  logic [W+1:0]   dbl;
  logic [W+1:0]   t1;
  logic [W+1:0]   t2;
  logic [W+1:0]   mx;

  // one step: shift in one bit (restoring reduction), or double-and-add
  always_comb begin
    mx  = {2'b00, mm};
    if (op == dsa_pkg::OP_MULMOD) begin
      dbl = {acc, 1'b0};
      t1  = (dbl >= mx) ? dbl - mx : dbl;
      t2  = sh[2*W-1] ? t1 + {2'b00, bb} : t1;
      t2  = (t2 >= mx) ? t2 - mx : t2;
    end else begin
      dbl = {acc, sh[2*W-1]};
      t1  = (dbl >= mx) ? dbl - mx : dbl;
      t2  = t1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        op   <= ctl.op;
        mm   <= m;
        acc  <= '0;
        cnt  <= (ctl.op == dsa_pkg::OP_MULMOD) ? 7'(W) : 7'(2*W);
        if (ctl.op == dsa_pkg::OP_MULMOD) begin
          sh <= {a[W-1:0], {W{1'b0}}};
          bb <= (b >= m) ? b - m : b;
        end else begin
          sh <= a;
        end
      end else if (busy) begin
        acc <= t2[W:0];
        sh  <= {sh[2*W-2:0], (op != dsa_pkg::OP_MULMOD) && (dbl >= mx)};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quo = sh;
  assign rem = acc[W-1:0];
endmodule

### sv/dsa_sign_verify_top.sv
// Top level of the DSA sign and verify engine.
//  channel | signals                          | transfer
//  in      | in_valid in_ready in_data        | valid and ready high
//  out     | out_valid out_ready out_data     | valid and ready high
//  cfg     | cfg_we cfg_index cfg_data        | cfg_we high
// One item at a time: the sequencer issues each modular multiply, reduce
// or divide to the bit-serial unit and waits for it to finish; an exponent
// takes a square and at most one multiply per bit, an inverse a divide and
// a multiply per Euclid step.
// Synchronous reset sets config and state registers at once, no clearing pass.
// in_ready is low while an item is in work or its result waits on out_ready.
module dsa_sign_verify_top #(
  parameter int unsigned MOD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dsa_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dsa_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [MOD_BITS-1:0] cfg_data
);
  localparam int unsigned W = dsa_pkg::W;

  // configuration registers
  logic [W-1:0] p, q, g, x, y;
  always_ff @(posedge clk) begin
    if (rst) begin
      p <= W'(23); q <= W'(11); g <= W'(4); x <= W'(3); y <= W'(18);
    end else if (cfg_we) begin
      case (cfg_index)
        dsa_pkg::REG_P: p <= W'(cfg_data);
        dsa_pkg::REG_Q: q <= W'(cfg_data);
        dsa_pkg::REG_G: g <= W'(cfg_data);
        dsa_pkg::REG_X: x <= W'(cfg_data);
        dsa_pkg::REG_Y: y <= W'(cfg_data);
        default: ;
      endcase
    end
  end

  dsa_pkg::state_t state, state_next, ret;
  dsa_pkg::in_item_t item;

  // working registers
  logic [W-1:0] r0, r1, qt, inv, pb, pe, pm, pacc, pret, ret_ra;
  logic [W-1:0] t0m, t1m;            // magnitudes of Euclid coefficients
  logic         t0n, t1n;            // their signs
  logic [W-1:0] va, vb, vc, vres;
  dsa_pkg::state_t pw_ret;
  dsa_pkg::out_item_t res;

  dsa_pkg::unit_ctl_t  uctl;
  dsa_pkg::unit_sts_t  usts;
  logic [2*W-1:0]      ua, uquo;
  logic [W-1:0]        ub, um, urem;

  dsa_serial_unit u_unit (
    .clk(clk), .rst(rst), .ctl(uctl), .a(ua), .b(ub), .m(um),
    .sts(usts), .quo(uquo), .rem(urem)
  );

  // Euclid coefficient update tn = t0 - qt*t1, with qt*t1 in vres
  logic [W:0] tn_sum;
  logic       tn_neg;
  logic [W-1:0] tn_mag;
  always_comb begin
    tn_sum = '0; tn_neg = 1'b0; tn_mag = '0;
    if (t0n == t1n) begin
      // t0 - sign*|prod|: same signs subtract magnitudes
      if (t0m >= vres) begin
        tn_mag = t0m - vres; tn_neg = t0n;
      end else begin
        tn_mag = vres - t0m; tn_neg = ~t0n;
      end
    end else begin
      tn_sum = {1'b0, t0m} + {1'b0, vres};
      tn_mag = tn_sum[W-1:0]; tn_neg = t0n;
    end
    if (tn_mag == '0) tn_neg = 1'b0;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dsa_pkg::S_IDLE:      if (in_valid) state_next = dsa_pkg::S_CHECK;
      dsa_pkg::S_CHECK:     state_next = (p == '0 || q == '0) ? dsa_pkg::S_FAIL :
                              (item.kind == dsa_pkg::KIND_SIGN) ? dsa_pkg::S_PW_INIT :
                              dsa_pkg::S_INV_INIT;
      dsa_pkg::S_INV_INIT:  state_next = (q < W'(2)) ? dsa_pkg::S_FAIL : dsa_pkg::S_INV_RED;
      dsa_pkg::S_INV_RED:   state_next = dsa_pkg::S_INV_RED_W;
      dsa_pkg::S_INV_RED_W: if (usts.done) state_next = dsa_pkg::S_INV_TEST;
      dsa_pkg::S_INV_TEST:  state_next = (r1 == '0) ? dsa_pkg::S_INV_END : dsa_pkg::S_INV_DIV;
      dsa_pkg::S_INV_DIV:   state_next = dsa_pkg::S_INV_DIV_W;
      dsa_pkg::S_INV_DIV_W: if (usts.done) state_next = dsa_pkg::S_INV_MUL;
      dsa_pkg::S_INV_MUL:   state_next = dsa_pkg::S_INV_MUL_W;
      dsa_pkg::S_INV_MUL_W: if (usts.done) state_next = dsa_pkg::S_INV_UPD;
      dsa_pkg::S_INV_UPD:   state_next = dsa_pkg::S_INV_TEST;
      dsa_pkg::S_INV_END:   state_next = (r0 != W'(1)) ? dsa_pkg::S_FAIL : ret;
      dsa_pkg::S_PW_INIT:   state_next = dsa_pkg::S_PW_BRED;
      dsa_pkg::S_PW_BRED:   state_next = dsa_pkg::S_PW_BRED_W;
      dsa_pkg::S_PW_BRED_W: if (usts.done) state_next = dsa_pkg::S_PW_BIT;
      dsa_pkg::S_PW_BIT:    state_next = (pe == '0) ? dsa_pkg::S_PW_DONE :
                              pe[0] ? dsa_pkg::S_PW_ACC : dsa_pkg::S_PW_SQ;
      dsa_pkg::S_PW_ACC:    state_next = dsa_pkg::S_PW_ACC_W;
      dsa_pkg::S_PW_ACC_W:  if (usts.done) state_next = dsa_pkg::S_PW_SQ;
      dsa_pkg::S_PW_SQ:     state_next = dsa_pkg::S_PW_SQ_W;
      dsa_pkg::S_PW_SQ_W:   if (usts.done) state_next = dsa_pkg::S_PW_BIT;
      dsa_pkg::S_PW_DONE:   state_next = pw_ret;
      dsa_pkg::S_SG_R:      state_next = dsa_pkg::S_SG_R_W;
      dsa_pkg::S_SG_R_W:    if (usts.done) state_next = dsa_pkg::S_INV_INIT;
      dsa_pkg::S_SG_INV:    state_next = dsa_pkg::S_SG_H;
      dsa_pkg::S_SG_H:      state_next = dsa_pkg::S_SG_H_W;
      dsa_pkg::S_SG_H_W:    if (usts.done) state_next = dsa_pkg::S_SG_X;
      dsa_pkg::S_SG_X:      state_next = dsa_pkg::S_SG_X_W;
      dsa_pkg::S_SG_X_W:    if (usts.done) state_next = dsa_pkg::S_SG_XR;
      dsa_pkg::S_SG_XR:     state_next = dsa_pkg::S_SG_XR_W;
      dsa_pkg::S_SG_XR_W:   if (usts.done) state_next = dsa_pkg::S_SG_ADD;
      dsa_pkg::S_SG_ADD:    state_next = dsa_pkg::S_SG_ADD_W;
      dsa_pkg::S_SG_ADD_W:  if (usts.done) state_next = dsa_pkg::S_SG_S;
      dsa_pkg::S_SG_S:      state_next = dsa_pkg::S_SG_S_W;
      dsa_pkg::S_SG_S_W:    if (usts.done) state_next = dsa_pkg::S_DONE;
      dsa_pkg::S_VF_U1:     state_next = dsa_pkg::S_VF_U1_W;
      dsa_pkg::S_VF_U1_W:   if (usts.done) state_next = dsa_pkg::S_VF_U2;
      dsa_pkg::S_VF_U2:     state_next = dsa_pkg::S_VF_U2_W;
      dsa_pkg::S_VF_U2_W:   if (usts.done) state_next = dsa_pkg::S_PW_INIT;
      dsa_pkg::S_VF_T1:     state_next = dsa_pkg::S_PW_INIT;
      dsa_pkg::S_VF_T2:     state_next = dsa_pkg::S_VF_M;
      dsa_pkg::S_VF_M:      state_next = dsa_pkg::S_VF_M_W;
      dsa_pkg::S_VF_M_W:    if (usts.done) state_next = dsa_pkg::S_VF_V;
      dsa_pkg::S_VF_V:      state_next = dsa_pkg::S_VF_V_W;
      dsa_pkg::S_VF_V_W:    if (usts.done) state_next = dsa_pkg::S_DONE;
      dsa_pkg::S_FAIL:      state_next = dsa_pkg::S_OUT;
      dsa_pkg::S_DONE:      state_next = dsa_pkg::S_OUT;
      dsa_pkg::S_OUT:       if (out_ready) state_next = dsa_pkg::S_IDLE;
      default:              state_next = dsa_pkg::S_IDLE;
    endcase
  end

  // unit commands
  always_comb begin
    uctl.start = 1'b0;
    uctl.op    = dsa_pkg::OP_MULMOD;
    ua = '0; ub = '0; um = q;
    case (state)
      dsa_pkg::S_INV_RED: begin
        uctl.start = 1'b1; uctl.op = dsa_pkg::OP_RED; ua = {{W{1'b0}}, va};
      end
      dsa_pkg::S_INV_DIV: begin
        uctl.start = 1'b1; uctl.op = dsa_pkg::OP_DIV; ua = {{W{1'b0}}, r0}; um = r1;
      end
      dsa_pkg::S_INV_MUL: begin
        // qt*|t1| never exceeds q, so reducing by an all-ones modulus is exact
        uctl.start = 1'b1; ua = {{W{1'b0}}, qt}; ub = t1m; um = '1;
      end
      dsa_pkg::S_PW_BRED: begin
        uctl.start = 1'b1; uctl.op = dsa_pkg::OP_RED; ua = {{W{1'b0}}, pb}; um = pm;
      end
      dsa_pkg::S_PW_ACC: begin
        uctl.start = 1'b1; ua = {{W{1'b0}}, pacc}; ub = pb; um = pm;
      end
      dsa_pkg::S_PW_SQ: begin
        uctl.start = 1'b1; ua = {{W{1'b0}}, pb}; ub = pb; um = pm;
      end
      dsa_pkg::S_SG_R: begin
        uctl.start = 1'b1; uctl.op = dsa_pkg::OP_RED; ua = {{W{1'b0}}, pret};
      end
      dsa_pkg::S_SG_H: begin
        uctl.start = 1'b1; uctl.op = dsa_pkg::OP_RED; ua = {{W{1'b0}}, item.hash_value};
      end
      dsa_pkg::S_SG_X: begin
        uctl.start = 1'b1; uctl.op = dsa_pkg::OP_RED; ua = {{W{1'b0}}, x};
      end
      dsa_pkg::S_SG_XR: begin
        uctl.start = 1'b1; ua = {{W{1'b0}}, vb}; ub = ret_ra;
      end
      dsa_pkg::S_SG_ADD: begin
        uctl.start = 1'b1; uctl.op = dsa_pkg::OP_RED;
        ua = {{(W-1){1'b0}}, {1'b0, va} + {1'b0, vres}};
      end
      dsa_pkg::S_SG_S: begin
        uctl.start = 1'b1; ua = {{W{1'b0}}, inv}; ub = vres;
      end
      dsa_pkg::S_VF_U1: begin
        uctl.start = 1'b1; ua = {{W{1'b0}}, item.hash_value}; ub = inv;
      end
      dsa_pkg::S_VF_U2: begin
        uctl.start = 1'b1; ua = {{W{1'b0}}, item.sig_r}; ub = inv;
      end
      dsa_pkg::S_VF_M: begin
        uctl.start = 1'b1; ua = {{W{1'b0}}, va}; ub = pret; um = p;
      end
      dsa_pkg::S_VF_V: begin
        uctl.start = 1'b1; uctl.op = dsa_pkg::OP_RED; ua = {{W{1'b0}}, vres};
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
    case (state)
      dsa_pkg::S_IDLE: begin
        item <= in_data;
        if (in_data.kind == dsa_pkg::KIND_SIGN) begin
          pb <= g; pe <= in_data.nonce; pw_ret <= dsa_pkg::S_SG_R;
          ret <= dsa_pkg::S_SG_INV; va <= in_data.nonce;
        end else begin
          ret <= dsa_pkg::S_VF_U1; va <= in_data.sig_s;
        end
      end
      dsa_pkg::S_INV_INIT: begin
        t0m <= '0; t0n <= 1'b0; t1m <= W'(1); t1n <= 1'b0; r0 <= q;
      end
      dsa_pkg::S_INV_RED_W: if (usts.done) r1 <= urem;
      dsa_pkg::S_INV_DIV_W: if (usts.done) begin
        qt <= uquo[W-1:0]; vc <= urem;
      end
      dsa_pkg::S_INV_MUL_W: if (usts.done) vres <= urem;
      dsa_pkg::S_INV_UPD: begin
        r0 <= r1; r1 <= vc;
        t0m <= t1m; t0n <= t1n;
        t1m <= tn_mag; t1n <= tn_neg;
      end
      dsa_pkg::S_INV_END: inv <= t0n ? q - t0m : t0m;
      dsa_pkg::S_PW_INIT: begin
        pm <= p; pacc <= W'(1);
      end
      dsa_pkg::S_PW_BRED_W: if (usts.done) pb <= urem;
      dsa_pkg::S_PW_ACC_W:  if (usts.done) pacc <= urem;
      dsa_pkg::S_PW_SQ_W:   if (usts.done) begin
        pb <= urem; pe <= pe >> 1;
      end
      dsa_pkg::S_PW_DONE: pret <= pacc;
      dsa_pkg::S_SG_R_W: if (usts.done) ret_ra <= urem;
      dsa_pkg::S_SG_H_W: if (usts.done) va <= urem;
      dsa_pkg::S_SG_X_W: if (usts.done) vb <= urem;
      dsa_pkg::S_SG_XR_W, dsa_pkg::S_SG_ADD_W, dsa_pkg::S_VF_M_W:
        if (usts.done) vres <= urem;
      dsa_pkg::S_SG_S_W: if (usts.done) begin
        res.out_r <= ret_ra; res.out_s <= urem; res.valid_res <= 1'b0; res.status <= 1'b0;
      end
      dsa_pkg::S_VF_U1_W: if (usts.done) va <= urem;
      dsa_pkg::S_VF_U2_W: if (usts.done) begin
        vb <= urem; pb <= g; pe <= va; pw_ret <= dsa_pkg::S_VF_T1;
      end
      dsa_pkg::S_VF_T1: begin
        va <= pret; pb <= y; pe <= vb; pw_ret <= dsa_pkg::S_VF_T2;
      end
      dsa_pkg::S_VF_V_W: if (usts.done) begin
        res.out_r <= urem; res.out_s <= '0;
        res.valid_res <= (urem == item.sig_r); res.status <= 1'b0;
      end
      dsa_pkg::S_FAIL: begin
        res.out_r <= '0; res.out_s <= '0; res.valid_res <= 1'b0; res.status <= 1'b1;
      end
      default: ;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = (state == dsa_pkg::S_IDLE);
    out_valid = (state == dsa_pkg::S_OUT);
    out_data  = res;
  end

  // assertions
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input and output open together");
  a_ok_verify_zero_s: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.status && item.kind == dsa_pkg::KIND_VERIFY) |-> out_data.out_s == '0)
    else $error("verify result with nonzero s");
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status) |-> (out_data.out_r == '0 && !out_data.valid_res))
    else $error("failed item with nonzero fields");
  a_unit_idle: assert property (@(posedge clk) disable iff (rst)
    uctl.start |-> !usts.busy) else $error("unit started while busy");
endmodule
